[src/caf_pkg.sv]
// shared types, constants and register codes of the contrast autofocus sweep
// used by every module of the block; depends on nothing
package caf_pkg;

    // geometry
    localparam int WIN_LEN     = 5;
    localparam int POS_W       = 16;
    localparam int VAL_W       = 32;
    localparam int WIN_IDX_W   = $clog2(WIN_LEN);
    localparam int FILL_W      = $clog2(WIN_LEN + 1);
    localparam int WIN_CENTRE  = WIN_LEN / 2;
    localparam int SUM_W       = VAL_W + $clog2(WIN_LEN);

    // divide by window length: multiply by reciprocal, then one correction step
    localparam int DIV_K       = SUM_W + 1;
    localparam logic [DIV_K-1:0] DIV_RECIP = DIV_K'((65'd1 << DIV_K) / WIN_LEN);
    localparam int SPLIT_LO    = SUM_W / 2;
    localparam int SPLIT_HI    = SUM_W - SPLIT_LO;
    localparam int PROD_W      = SUM_W + DIV_K;

    // configuration widths
    localparam int RATIO_W     = 17;
    localparam int RISE_W      = 16;
    localparam int STEP_W      = 7;
    localparam int CFG_DATA_W  = 17;
    localparam int CFG_IDX_W   = 3;
    localparam int Q_SHIFT     = 16;

    // sweep control
    localparam int STEP_CNT_W  = 3;
    localparam logic [STEP_CNT_W-1:0] WARM_STEPS = STEP_CNT_W'(6);
    localparam logic [1:0] FALL_LIMIT = 2'd3;

    // input queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // action codes
    localparam logic ACT_START  = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    // step zones
    localparam logic [1:0] ZONE_INITIAL = 2'd0;
    localparam logic [1:0] ZONE_COARSE  = 2'd1;
    localparam logic [1:0] ZONE_MID     = 2'd2;
    localparam logic [1:0] ZONE_FINE    = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START_POSITION = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_POSITION   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COARSE_RATIO   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RISE_RATIO     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_STEP   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COARSE_STEP    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MID_STEP       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FINE_STEP      = 3'd7;

    typedef struct packed {
        logic [POS_W-1:0]   start_position;
        logic [POS_W-1:0]   end_position;
        logic [RATIO_W-1:0] coarse_ratio;
        logic [RISE_W-1:0]  rise_ratio;
        logic [STEP_W-1:0]  step_initial;
        logic [STEP_W-1:0]  step_coarse;
        logic [STEP_W-1:0]  step_mid;
        logic [STEP_W-1:0]  step_fine;
    } caf_cfg_t;

    typedef struct packed {
        logic              is_sample;
        logic [VAL_W-1:0]  value;
    } caf_item_t;

endpackage

[src/caf_cfg_regs.sv]
// configuration register file of the autofocus sweep
// depends on caf_pkg for register codes, widths and the config struct
module caf_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [caf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [caf_pkg::CFG_DATA_W-1:0]   cfg_data,
    output caf_pkg::caf_cfg_t                cfg
);

    caf_pkg::caf_cfg_t cfg_reg;
    caf_pkg::caf_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                caf_pkg::REG_START_POSITION:
                    cfg_next.start_position = cfg_data[caf_pkg::POS_W-1:0];
                caf_pkg::REG_END_POSITION:
                    cfg_next.end_position = cfg_data[caf_pkg::POS_W-1:0];
                caf_pkg::REG_COARSE_RATIO:
                    cfg_next.coarse_ratio = cfg_data[caf_pkg::RATIO_W-1:0];
                caf_pkg::REG_RISE_RATIO:
                    cfg_next.rise_ratio = cfg_data[caf_pkg::RISE_W-1:0];
                caf_pkg::REG_INITIAL_STEP:
                    cfg_next.step_initial = cfg_data[caf_pkg::STEP_W-1:0];
                caf_pkg::REG_COARSE_STEP:
                    cfg_next.step_coarse = cfg_data[caf_pkg::STEP_W-1:0];
                caf_pkg::REG_MID_STEP:
                    cfg_next.step_mid = cfg_data[caf_pkg::STEP_W-1:0];
                caf_pkg::REG_FINE_STEP:
                    cfg_next.step_fine = cfg_data[caf_pkg::STEP_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_position <= '0;
            cfg_reg.end_position   <= caf_pkg::POS_W'(1023);
            cfg_reg.coarse_ratio   <= caf_pkg::RATIO_W'(52429);
            cfg_reg.rise_ratio     <= caf_pkg::RISE_W'(262);
            cfg_reg.step_initial   <= caf_pkg::STEP_W'(1);
            cfg_reg.step_coarse    <= caf_pkg::STEP_W'(8);
            cfg_reg.step_mid       <= caf_pkg::STEP_W'(3);
            cfg_reg.step_fine      <= caf_pkg::STEP_W'(1);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[src/caf_front.sv]
// input side of the autofocus sweep: accepts items, classifies start/sample
// and holds them in a short queue for the back end; depends on caf_pkg
module caf_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         action,
    input  logic [caf_pkg::VAL_W-1:0]    focus_value,
    output logic                         head_valid,
    output caf_pkg::caf_item_t           head,
    input  logic                         pop
);

    caf_pkg::caf_item_t              queue_reg [caf_pkg::QUEUE_DEPTH];
    logic [caf_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [caf_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [caf_pkg::QCNT_W-1:0]      count_reg, count_next;
    logic                            push;
    logic                            take;
    caf_pkg::caf_item_t              item_in;

    assign in_stall   = (count_reg == caf_pkg::QCNT_W'(caf_pkg::QUEUE_DEPTH));
    assign push       = in_valid && !in_stall;
    assign head_valid = (count_reg != '0);
    assign take       = pop && head_valid;
    assign head       = queue_reg[rd_ptr_reg];

    always_comb
    begin
        item_in.is_sample = (action == caf_pkg::ACT_SAMPLE);
        item_in.value     = focus_value;
    end

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            if (wr_ptr_reg == caf_pkg::QPTR_W'(caf_pkg::QUEUE_DEPTH - 1))
                wr_ptr_next = '0;
            else
                wr_ptr_next = wr_ptr_reg + caf_pkg::QPTR_W'(1);
        end
        if (take)
        begin
            if (rd_ptr_reg == caf_pkg::QPTR_W'(caf_pkg::QUEUE_DEPTH - 1))
                rd_ptr_next = '0;
            else
                rd_ptr_next = rd_ptr_reg + caf_pkg::QPTR_W'(1);
        end
        if (push && !take)
            count_next = count_reg + caf_pkg::QCNT_W'(1);
        else if (take && !push)
            count_next = count_reg - caf_pkg::QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            queue_reg[wr_ptr_reg] <= item_in;
    end

endmodule

[src/caf_back.sv]
// sweep engine of the autofocus block: window, averages, peak tracking,
// zone choice, lens move and the result register; depends on caf_pkg
module caf_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  caf_pkg::caf_cfg_t             cfg,
    input  logic                          head_valid,
    input  caf_pkg::caf_item_t            head,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [caf_pkg::POS_W-1:0]     next_position,
    output logic [1:0]                    step_zone,
    output logic [caf_pkg::POS_W-1:0]     best_position,
    output logic                          finished
);

    localparam logic [2:0] ST_ACT  = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_RED  = 3'd2;
    localparam logic [2:0] ST_FIX  = 3'd3;
    localparam logic [2:0] ST_ZONE = 3'd4;

    localparam int CP_W = caf_pkg::RATIO_W + caf_pkg::VAL_W;
    localparam int RP_W = caf_pkg::RISE_W + caf_pkg::VAL_W;

    logic [2:0] state_reg, state_next;

    // sweep state
    logic [caf_pkg::VAL_W-1:0]      win_val_reg [caf_pkg::WIN_LEN];
    logic [caf_pkg::POS_W-1:0]      win_pos_reg [caf_pkg::WIN_LEN];
    logic [caf_pkg::FILL_W-1:0]     fill_reg, fill_next;
    logic [caf_pkg::SUM_W-1:0]      sum_reg, sum_next;
    logic [caf_pkg::VAL_W-1:0]      avg_now_reg, avg_now_next;
    logic [caf_pkg::VAL_W-1:0]      avg_before_reg, avg_before_next;
    logic [caf_pkg::VAL_W-1:0]      avg_peak_reg, avg_peak_next;
    logic [caf_pkg::POS_W-1:0]      peak_pos_reg, peak_pos_next;
    logic [caf_pkg::POS_W-1:0]      lens_reg, lens_next;
    logic [caf_pkg::STEP_CNT_W-1:0] step_cnt_reg, step_cnt_next;
    logic [1:0]                     zone_reg, zone_next;
    logic [1:0]                     fall_reg, fall_next;
    logic                           sweeping_reg, sweeping_next;

    // per-item flags
    logic upd_reg, upd_next;
    logic stop_reg, stop_next;
    logic grew_reg, grew_next;

    // arithmetic pipeline
    logic [caf_pkg::SPLIT_HI+caf_pkg::DIV_K-1:0] pp_hi_reg;
    logic [caf_pkg::SPLIT_LO+caf_pkg::DIV_K-1:0] pp_lo_reg;
    logic [caf_pkg::VAL_W-1:0]                   quot_reg;
    logic [CP_W-1:0]                             cp_reg;
    logic [RP_W-1:0]                             rp_reg;
    logic [caf_pkg::PROD_W-1:0]                  prod;
    logic [caf_pkg::SUM_W-1:0]                   rem;
    logic [caf_pkg::VAL_W-1:0]                   avg_fix;
    logic [caf_pkg::VAL_W-1:0]                   rise_base;

    // result register
    logic                       out_valid_reg, out_valid_next;
    logic [caf_pkg::POS_W-1:0]  out_pos_reg;
    logic [1:0]                 out_zone_reg;
    logic [caf_pkg::POS_W-1:0]  out_best_reg;
    logic                       out_fin_reg;
    logic                       out_free;
    logic                       emit;
    logic [caf_pkg::POS_W-1:0]  res_pos;
    logic [1:0]                 res_zone;
    logic [caf_pkg::POS_W-1:0]  res_best;
    logic                       res_fin;

    // window write controls
    logic push_en;
    logic shift_en;

    // zone choice
    logic                        coarse_hit;
    logic                        rise_hit;
    logic signed [caf_pkg::VAL_W:0] diff;
    logic                        diff_pos;
    logic                        diff_neg;
    logic [1:0]                  fall_bump;
    logic [1:0]                  zone_pick;
    logic [1:0]                  fall_pick;
    logic [caf_pkg::STEP_W-1:0]  step;
    logic [caf_pkg::POS_W:0]     lens_sum;
    logic [caf_pkg::POS_W-1:0]   lens_moved;

    assign out_free = !out_valid_reg || !out_stall;

    // averaging datapath
    assign prod = {pp_hi_reg, {caf_pkg::SPLIT_LO{1'b0}}} + caf_pkg::PROD_W'(pp_lo_reg);
    assign rem  = sum_reg - caf_pkg::SUM_W'(quot_reg) * caf_pkg::SUM_W'(caf_pkg::WIN_LEN);
    assign avg_fix = quot_reg + caf_pkg::VAL_W'(rem >= caf_pkg::SUM_W'(caf_pkg::WIN_LEN));
    assign rise_base = upd_reg ? avg_now_reg : avg_before_reg;

    // zone choice from registered products
    always_comb
    begin
        // a fresh peak equals the average, so only the ratio itself decides
        if (grew_reg)
            coarse_hit = cfg.coarse_ratio[caf_pkg::RATIO_W-1];
        else
            coarse_hit = (CP_W'({avg_now_reg, {caf_pkg::Q_SHIFT{1'b0}}}) <= cp_reg);
        diff     = $signed({1'b0, avg_now_reg}) - $signed({1'b0, avg_before_reg});
        rise_hit = ($signed({diff, {caf_pkg::Q_SHIFT{1'b0}}}) > $signed({1'b0, rp_reg}));
        diff_neg = diff[caf_pkg::VAL_W];
        diff_pos = !diff_neg && (diff != '0);
        fall_bump = (zone_reg == caf_pkg::ZONE_FINE) ? fall_reg + 2'd1 : fall_reg;

        zone_pick = zone_reg;
        fall_pick = fall_reg;
        priority if (step_cnt_reg < caf_pkg::WARM_STEPS)
        begin
            zone_pick = caf_pkg::ZONE_INITIAL;
        end
        else if (coarse_hit)
        begin
            zone_pick = caf_pkg::ZONE_COARSE;
            fall_pick = '0;
        end
        else if (rise_hit)
        begin
            zone_pick = caf_pkg::ZONE_FINE;
            fall_pick = '0;
        end
        else if (zone_reg == caf_pkg::ZONE_FINE && diff_pos)
        begin
            fall_pick = '0;
        end
        else if (diff_neg)
        begin
            if (fall_bump >= caf_pkg::FALL_LIMIT)
            begin
                zone_pick = caf_pkg::ZONE_MID;
                fall_pick = '0;
            end
            else
            begin
                fall_pick = fall_bump;
            end
        end
        else
        begin
            zone_pick = caf_pkg::ZONE_MID;
            fall_pick = '0;
        end

        unique case (zone_pick)
            caf_pkg::ZONE_INITIAL: step = cfg.step_initial;
            caf_pkg::ZONE_COARSE:  step = cfg.step_coarse;
            caf_pkg::ZONE_MID:     step = cfg.step_mid;
            caf_pkg::ZONE_FINE:    step = cfg.step_fine;
        endcase

        lens_sum = {1'b0, lens_reg} + (caf_pkg::POS_W + 1)'(step);
        lens_moved = lens_sum[caf_pkg::POS_W] ? {caf_pkg::POS_W{1'b1}}
                                              : lens_sum[caf_pkg::POS_W-1:0];
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        sum_next        = sum_reg;
        avg_now_next    = avg_now_reg;
        avg_before_next = avg_before_reg;
        avg_peak_next   = avg_peak_reg;
        peak_pos_next   = peak_pos_reg;
        lens_next       = lens_reg;
        step_cnt_next   = step_cnt_reg;
        zone_next       = zone_reg;
        fall_next       = fall_reg;
        sweeping_next   = sweeping_reg;
        upd_next        = upd_reg;
        stop_next       = stop_reg;
        grew_next       = grew_reg;
        pop             = 1'b0;
        push_en         = 1'b0;
        shift_en        = 1'b0;
        emit            = 1'b0;
        res_pos         = lens_reg;
        res_zone        = zone_reg;
        res_best        = peak_pos_reg;
        res_fin         = 1'b1;

        unique case (state_reg)
            ST_ACT:
            begin
                if (head_valid)
                begin
                    if (!head.is_sample)
                    begin
                        if (out_free)
                        begin
                            pop             = 1'b1;
                            emit            = 1'b1;
                            fill_next       = '0;
                            sum_next        = '0;
                            avg_now_next    = '0;
                            avg_before_next = '0;
                            avg_peak_next   = '0;
                            lens_next       = cfg.start_position;
                            peak_pos_next   = cfg.start_position;
                            step_cnt_next   = '0;
                            zone_next       = caf_pkg::ZONE_INITIAL;
                            fall_next       = '0;
                            sweeping_next   = 1'b1;
                            res_pos         = cfg.start_position;
                            res_zone        = caf_pkg::ZONE_INITIAL;
                            res_best        = cfg.start_position;
                            res_fin         = 1'b0;
                        end
                    end
                    else if (!sweeping_reg)
                    begin
                        if (out_free)
                        begin
                            pop  = 1'b1;
                            emit = 1'b1;
                        end
                    end
                    else
                    begin
                        pop       = 1'b1;
                        upd_next  = 1'b0;
                        grew_next = 1'b0;
                        stop_next = (lens_reg < cfg.start_position) ||
                                    (lens_reg >= cfg.end_position);
                        // the sample right after a start belongs to the start position
                        if (step_cnt_reg != '0)
                        begin
                            if (fill_reg < caf_pkg::FILL_W'(caf_pkg::WIN_LEN))
                            begin
                                push_en   = 1'b1;
                                fill_next = fill_reg + caf_pkg::FILL_W'(1);
                                sum_next  = sum_reg + caf_pkg::SUM_W'(head.value);
                            end
                            else
                            begin
                                shift_en = 1'b1;
                                upd_next = 1'b1;
                                sum_next = sum_reg - caf_pkg::SUM_W'(win_val_reg[0])
                                         + caf_pkg::SUM_W'(head.value);
                            end
                        end
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                state_next = upd_reg ? ST_RED : ST_ZONE;
            end
            ST_RED:
            begin
                state_next = ST_FIX;
            end
            ST_FIX:
            begin
                avg_before_next = avg_now_reg;
                avg_now_next    = avg_fix;
                if (avg_fix > avg_peak_reg)
                begin
                    avg_peak_next = avg_fix;
                    peak_pos_next = win_pos_reg[caf_pkg::WIN_CENTRE];
                    grew_next     = 1'b1;
                end
                state_next = ST_ZONE;
            end
            ST_ZONE:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = ST_ACT;
                    if (stop_reg)
                    begin
                        sweeping_next = 1'b0;
                    end
                    else
                    begin
                        zone_next = zone_pick;
                        fall_next = fall_pick;
                        lens_next = lens_moved;
                        if (step_cnt_reg < caf_pkg::WARM_STEPS)
                            step_cnt_next = step_cnt_reg + caf_pkg::STEP_CNT_W'(1);
                        res_pos  = lens_moved;
                        res_zone = zone_pick;
                        res_fin  = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_ACT;
            end
        endcase
    end

    assign out_valid_next = emit || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_ACT;
            fill_reg       <= '0;
            sum_reg        <= '0;
            avg_now_reg    <= '0;
            avg_before_reg <= '0;
            avg_peak_reg   <= '0;
            peak_pos_reg   <= '0;
            lens_reg       <= '0;
            step_cnt_reg   <= '0;
            zone_reg       <= caf_pkg::ZONE_INITIAL;
            fall_reg       <= '0;
            sweeping_reg   <= 1'b0;
            upd_reg        <= 1'b0;
            stop_reg       <= 1'b0;
            grew_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            sum_reg        <= sum_next;
            avg_now_reg    <= avg_now_next;
            avg_before_reg <= avg_before_next;
            avg_peak_reg   <= avg_peak_next;
            peak_pos_reg   <= peak_pos_next;
            lens_reg       <= lens_next;
            step_cnt_reg   <= step_cnt_next;
            zone_reg       <= zone_next;
            fall_reg       <= fall_next;
            sweeping_reg   <= sweeping_next;
            upd_reg        <= upd_next;
            stop_reg       <= stop_next;
            grew_reg       <= grew_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // window, arithmetic pipeline and result payload
    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            win_val_reg[fill_reg[caf_pkg::WIN_IDX_W-1:0]] <= head.value;
            win_pos_reg[fill_reg[caf_pkg::WIN_IDX_W-1:0]] <= lens_reg;
        end
        else if (shift_en)
        begin
            for (int i = 0; i < caf_pkg::WIN_LEN - 1; i++)
            begin
                win_val_reg[i] <= win_val_reg[i+1];
                win_pos_reg[i] <= win_pos_reg[i+1];
            end
            win_val_reg[caf_pkg::WIN_LEN-1] <= head.value;
            win_pos_reg[caf_pkg::WIN_LEN-1] <= lens_reg;
        end

        if (state_reg == ST_MUL)
        begin
            pp_hi_reg <= (caf_pkg::SPLIT_HI + caf_pkg::DIV_K)'(
                             sum_reg[caf_pkg::SUM_W-1:caf_pkg::SPLIT_LO])
                       * (caf_pkg::SPLIT_HI + caf_pkg::DIV_K)'(caf_pkg::DIV_RECIP);
            pp_lo_reg <= (caf_pkg::SPLIT_LO + caf_pkg::DIV_K)'(
                             sum_reg[caf_pkg::SPLIT_LO-1:0])
                       * (caf_pkg::SPLIT_LO + caf_pkg::DIV_K)'(caf_pkg::DIV_RECIP);
            cp_reg <= CP_W'(cfg.coarse_ratio) * CP_W'(avg_peak_reg);
            rp_reg <= RP_W'(cfg.rise_ratio) * RP_W'(rise_base);
        end

        if (state_reg == ST_RED)
            quot_reg <= prod[caf_pkg::DIV_K +: caf_pkg::VAL_W];

        if (emit)
        begin
            out_pos_reg  <= res_pos;
            out_zone_reg <= res_zone;
            out_best_reg <= res_best;
            out_fin_reg  <= res_fin;
        end
    end

    assign out_valid     = out_valid_reg;
    assign next_position = out_pos_reg;
    assign step_zone     = out_zone_reg;
    assign best_position = out_best_reg;
    assign finished      = out_fin_reg;

endmodule

[src/contrast_autofocus_sweep.sv]
// top level of the contrast hill-climb autofocus sweep controller
// depends on caf_pkg, caf_cfg_regs, caf_front and caf_back
//
// Each accepted item gives exactly one result. Items enter a two-entry queue,
// so the input keeps taking transfers, until both entries are full, while the
// engine works and while a finished result waits in the output register. A
// start item or a sample outside a sweep passes only the act state; a sample
// while the five-entry window is still filling, or the first sample after a
// start, passes the act, multiply and zone states; a sample with a full
// window passes act (window update), multiply, reduce, fix (split reciprocal
// multiply beside threshold products, sum, divide correction) and zone choice.
// Registers are read live; write them only while the block is idle.
module contrast_autofocus_sweep (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [caf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [caf_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             action,
    input  logic [caf_pkg::VAL_W-1:0]        focus_value,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [caf_pkg::POS_W-1:0]        next_position,
    output logic [1:0]                       step_zone,
    output logic [caf_pkg::POS_W-1:0]        best_position,
    output logic                             finished
);

    caf_pkg::caf_cfg_t  cfg;
    caf_pkg::caf_item_t head;
    logic               head_valid;
    logic               pop;

    caf_cfg_regs u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cfg        (cfg)
    );

    caf_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .focus_value (focus_value),
        .head_valid  (head_valid),
        .head        (head),
        .pop         (pop)
    );

    caf_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .head_valid    (head_valid),
        .head          (head),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .next_position (next_position),
        .step_zone     (step_zone),
        .best_position (best_position),
        .finished      (finished)
    );

endmodule

[tb/caf_sweep_checker.sv]
`timescale 1ns / 100ps
// scoreboard for the contrast autofocus sweep: snoops register writes and both channels,
// keeps its own copy of the sweep state and compares every result field by field
// depends on caf_pkg
module caf_sweep_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [caf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [caf_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             in_valid,
    input  logic                             in_stall,
    input  logic                             action,
    input  logic [caf_pkg::VAL_W-1:0]        focus_value,
    input  logic                             out_valid,
    input  logic                             out_stall,
    input  logic [caf_pkg::POS_W-1:0]        next_position,
    input  logic [1:0]                       step_zone,
    input  logic [caf_pkg::POS_W-1:0]        best_position,
    input  logic                             finished,
    output int                               mismatches,
    output int                               pending
);
    import caf_pkg::*;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic [1:0]       zone;
        logic [POS_W-1:0] best;
        logic             done;
    } sweep_move_t;

    sweep_move_t      expected_moves[$];
    caf_cfg_t         cfg;

    logic [VAL_W-1:0] win_val[WIN_LEN];
    logic [POS_W-1:0] win_pos[WIN_LEN];
    int               win_fill;
    logic [SUM_W-1:0] win_sum;
    logic [VAL_W-1:0] avg_now;
    logic [VAL_W-1:0] avg_prev;
    logic [VAL_W-1:0] avg_peak;
    logic [POS_W-1:0] peak_pos;
    logic [POS_W-1:0] lens_pos;
    int               steps_made;
    logic [1:0]       zone;
    int               falls;
    logic             sweeping;

    task automatic push_value(input logic [VAL_W-1:0] val);
        if (win_fill < WIN_LEN)
        begin
            win_val[win_fill] = val;
            win_pos[win_fill] = lens_pos;
            win_fill++;
            win_sum += val;
        end
        else
        begin
            win_sum -= win_val[0];
            for (int i = 0; i < WIN_LEN - 1; i++)
            begin
                win_val[i] = win_val[i + 1];
                win_pos[i] = win_pos[i + 1];
            end
            win_val[WIN_LEN - 1] = val;
            win_pos[WIN_LEN - 1] = lens_pos;
            win_sum += val;
            avg_prev = avg_now;
            avg_now = VAL_W'(win_sum / SUM_W'(WIN_LEN));
            if (avg_now > avg_peak)
            begin
                avg_peak = avg_now;
                peak_pos = win_pos[WIN_CENTRE];
            end
        end
    endtask

    task automatic choose_zone();
        logic [63:0] scaled;
        logic [63:0] coarse_lim;
        longint      diff;
        longint      rise_lim;
        scaled = {16'b0, avg_now, 16'b0};
        coarse_lim = {47'b0, cfg.coarse_ratio} * {32'b0, avg_peak};
        diff = $signed({32'b0, avg_now}) - $signed({32'b0, avg_prev});
        rise_lim = $signed({32'b0, avg_prev}) * $signed({48'b0, cfg.rise_ratio});
        if (steps_made < WARM_STEPS)
            zone = ZONE_INITIAL;
        else if (scaled <= coarse_lim)
        begin
            zone = ZONE_COARSE;
            falls = 0;
        end
        else if (diff * 65536 > rise_lim)
        begin
            zone = ZONE_FINE;
            falls = 0;
        end
        else if (zone == ZONE_FINE && diff > 0)
            falls = 0;
        else if (diff < 0)
        begin
            // only a fall while fine counts toward dropping back to mid
            if (zone == ZONE_FINE)
                falls++;
            if (falls >= FALL_LIMIT)
            begin
                zone = ZONE_MID;
                falls = 0;
            end
        end
        else
        begin
            zone = ZONE_MID;
            falls = 0;
        end
    endtask

    task automatic advance_sweep(input logic act, input logic [VAL_W-1:0] val,
                                 output sweep_move_t move);
        logic [POS_W:0]    moved;
        logic [STEP_W-1:0] step;
        logic              done;
        done = 1'b1;
        if (act == ACT_START)
        begin
            win_fill = 0;
            win_sum = '0;
            avg_now = '0;
            avg_prev = '0;
            avg_peak = '0;
            lens_pos = cfg.start_position;
            peak_pos = lens_pos;
            steps_made = 0;
            zone = ZONE_INITIAL;
            falls = 0;
            sweeping = 1'b1;
            done = 1'b0;
        end
        else if (sweeping)
        begin
            // the first sample belongs to the start position and stays out of the window
            if (steps_made != 0)
                push_value(val);
            if (lens_pos < cfg.start_position || lens_pos >= cfg.end_position)
                sweeping = 1'b0;
            else
            begin
                choose_zone();
                case (zone)
                    ZONE_COARSE: step = cfg.step_coarse;
                    ZONE_MID:    step = cfg.step_mid;
                    ZONE_FINE:   step = cfg.step_fine;
                    default:     step = cfg.step_initial;
                endcase
                moved = {1'b0, lens_pos} + step;
                lens_pos = moved[POS_W] ? '1 : moved[POS_W-1:0];
                if (steps_made < WARM_STEPS)
                    steps_made++;
                done = 1'b0;
            end
        end
        move.position = lens_pos;
        move.zone = zone;
        move.best = peak_pos;
        move.done = done;
    endtask

    task automatic flag_field(input string field, input int unsigned want,
                              input int unsigned seen);
        if (want !== seen)
        begin
            $display("%0t: %s expected %0d, actual %0d", $time, field, want, seen);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sweep_move_t want;
        if (!rst_n)
        begin
            cfg.start_position = 16'd0;
            cfg.end_position = 16'd1023;
            cfg.coarse_ratio = 17'd52429;
            cfg.rise_ratio = 16'd262;
            cfg.step_initial = 7'd1;
            cfg.step_coarse = 7'd8;
            cfg.step_mid = 7'd3;
            cfg.step_fine = 7'd1;
            win_fill = 0;
            win_sum = '0;
            avg_now = '0;
            avg_prev = '0;
            avg_peak = '0;
            peak_pos = '0;
            lens_pos = '0;
            steps_made = 0;
            zone = ZONE_INITIAL;
            falls = 0;
            sweeping = 1'b0;
            expected_moves.delete();
            mismatches = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_START_POSITION: cfg.start_position = cfg_data[POS_W-1:0];
                    REG_END_POSITION:   cfg.end_position = cfg_data[POS_W-1:0];
                    REG_COARSE_RATIO:   cfg.coarse_ratio = cfg_data[RATIO_W-1:0];
                    REG_RISE_RATIO:     cfg.rise_ratio = cfg_data[RISE_W-1:0];
                    REG_INITIAL_STEP:   cfg.step_initial = cfg_data[STEP_W-1:0];
                    REG_COARSE_STEP:    cfg.step_coarse = cfg_data[STEP_W-1:0];
                    REG_MID_STEP:       cfg.step_mid = cfg_data[STEP_W-1:0];
                    REG_FINE_STEP:      cfg.step_fine = cfg_data[STEP_W-1:0];
                    default: ;
                endcase
            end
            // compare before taking a new item so a same-edge input is never matched
            if (out_valid && !out_stall)
            begin
                if (expected_moves.size() == 0)
                begin
                    $display("%0t: result transfer expected none, actual pos %0d zone %0d",
                             $time, next_position, step_zone);
                    mismatches++;
                end
                else
                begin
                    want = expected_moves.pop_front();
                    flag_field("next_position", want.position, next_position);
                    flag_field("step_zone", want.zone, step_zone);
                    flag_field("best_position", want.best, best_position);
                    flag_field("finished", want.done, finished);
                end
            end
            if (in_valid && !in_stall)
            begin
                advance_sweep(action, focus_value, want);
                expected_moves.push_back(want);
            end
            pending = expected_moves.size();
        end
    end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// stimulus and verdict for the contrast autofocus sweep: directed corner sweeps, then
// randomized focus curves under changing register settings; depends on caf_pkg, caf_sweep_checker
module tb_top;
    import caf_pkg::*;

    localparam int IDLE_PCT     = 29;
    localparam int RANDOM_ITEMS = 960;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic                  action;
    logic [VAL_W-1:0]      focus_value;
    logic                  out_valid;
    logic                  out_stall;
    logic [POS_W-1:0]      next_position;
    logic [1:0]            step_zone;
    logic [POS_W-1:0]      best_position;
    logic                  finished;

    int                    mismatches;
    int                    pending;
    int                    items_sent;
    logic                  calm;

    contrast_autofocus_sweep u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .focus_value   (focus_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .next_position (next_position),
        .step_zone     (step_zone),
        .best_position (best_position),
        .finished      (finished)
    );

    caf_sweep_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .focus_value   (focus_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .next_position (next_position),
        .step_zone     (step_zone),
        .best_position (best_position),
        .finished      (finished),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    always @(negedge clk)
        out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);

    // one transfer; returns on the falling edge after it is taken
    task automatic send_item(input logic act, input logic [VAL_W-1:0] val);
        calm = (items_sent >= 400 && items_sent < 620);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        focus_value <= val;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
    endtask

    task automatic load_settings(input caf_cfg_t s);
        wait_idle();
        write_reg(REG_START_POSITION, CFG_DATA_W'(s.start_position));
        write_reg(REG_END_POSITION, CFG_DATA_W'(s.end_position));
        write_reg(REG_COARSE_RATIO, s.coarse_ratio);
        write_reg(REG_RISE_RATIO, CFG_DATA_W'(s.rise_ratio));
        write_reg(REG_INITIAL_STEP, CFG_DATA_W'(s.step_initial));
        write_reg(REG_COARSE_STEP, CFG_DATA_W'(s.step_coarse));
        write_reg(REG_MID_STEP, CFG_DATA_W'(s.step_mid));
        write_reg(REG_FINE_STEP, CFG_DATA_W'(s.step_fine));
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [STEP_W-1:0] pick_step();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return STEP_W'(64);
            3: return STEP_W'($urandom_range(0, 127));
            default: return STEP_W'($urandom_range(1, 12));
        endcase
    endfunction

    function automatic caf_cfg_t pick_settings();
        caf_cfg_t s;
        int       first;
        int       last;
        case ($urandom_range(0, 9))
            0: first = 0;
            1: first = 65535 - $urandom_range(0, 300);
            2: first = 65535;
            default: first = $urandom_range(0, 3000);
        endcase
        case ($urandom_range(0, 11))
            0: last = 0;
            1: last = 65535;
            2: last = $urandom_range(0, 65535);
            default: last = first + $urandom_range(10, 400);
        endcase
        if (last > 65535)
            last = 65535;
        s.start_position = POS_W'(first);
        s.end_position = POS_W'(last);
        case ($urandom_range(0, 9))
            0: s.coarse_ratio = '0;
            1: s.coarse_ratio = RATIO_W'(65536);
            2: s.coarse_ratio = '1;
            3: s.coarse_ratio = RATIO_W'($urandom_range(0, 131071));
            default: s.coarse_ratio = RATIO_W'($urandom_range(45000, 65536));
        endcase
        case ($urandom_range(0, 9))
            0: s.rise_ratio = '0;
            1: s.rise_ratio = '1;
            2: s.rise_ratio = RISE_W'($urandom_range(0, 65535));
            default: s.rise_ratio = RISE_W'($urandom_range(0, 2000));
        endcase
        s.step_initial = pick_step();
        s.step_coarse = pick_step();
        s.step_mid = pick_step();
        s.step_fine = pick_step();
        return s;
    endfunction

    // a start, then samples along a noisy hill so the window sees rises, a peak and falls
    task automatic run_sweep();
        int     n;
        int     top_at;
        longint height;
        longint slope;
        longint jitter;
        longint v;
        send_item(ACT_START, $urandom());
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(70, 150) : $urandom_range(4, 60);
        top_at = $urandom_range(0, n);
        if ($urandom_range(0, 3) == 0)
            height = {32'b0, $urandom()};
        else
            height = $urandom_range(1000, 5_000_000);
        slope = height >>> $urandom_range(3, 8);
        jitter = height >>> $urandom_range(4, 12);
        for (int i = 0; i <= n; i++)
        begin
            v = height - slope * ((i > top_at) ? i - top_at : top_at - i)
                + $urandom_range(0, 32'(jitter));
            if (v < 0)
                v = 0;
            if (v > 64'h0000_0000_FFFF_FFFF)
                v = 64'h0000_0000_FFFF_FFFF;
            if ($urandom_range(0, 19) == 0)
                v = {32'b0, $urandom()};
            send_item(ACT_SAMPLE, v[VAL_W-1:0]);
        end
    endtask

    initial
    begin
        caf_cfg_t s;
        int       base;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        action = ACT_START;
        focus_value = '0;
        calm = 1'b0;
        items_sent = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // sample before any start, then a sweep with the window full of maximum values
        send_item(ACT_SAMPLE, '1);
        send_item(ACT_START, '1);
        send_item(ACT_SAMPLE, '0);
        repeat (7) send_item(ACT_SAMPLE, '1);
        repeat (4) send_item(ACT_SAMPLE, '0);
        send_item(ACT_SAMPLE, 32'h8000_0000);
        send_item(ACT_SAMPLE, 32'h0000_0001);

        // position saturates at the top, then the sweep finishes and stays idle
        s.start_position = 16'd65500;
        s.end_position = '1;
        s.coarse_ratio = RATIO_W'(65536);
        s.rise_ratio = '1;
        s.step_initial = '1;
        s.step_coarse = '0;
        s.step_mid = STEP_W'(64);
        s.step_fine = '1;
        load_settings(s);
        send_item(ACT_START, '0);
        repeat (3) send_item(ACT_SAMPLE, 32'h5555_5555);

        // start above end finishes at once
        s.start_position = 16'd300;
        s.end_position = 16'd200;
        load_settings(s);
        send_item(ACT_START, 32'hAAAA_AAAA);
        send_item(ACT_SAMPLE, 32'h1234_5678);

        // start raised mid-sweep: lens below start ends the sweep
        s.start_position = '0;
        s.end_position = '1;
        load_settings(s);
        send_item(ACT_START, '0);
        send_item(ACT_SAMPLE, 32'd100);
        s.start_position = 16'd60000;
        load_settings(s);
        send_item(ACT_SAMPLE, 32'd200);

        base = items_sent;
        while (items_sent - base < RANDOM_ITEMS)
        begin
            load_settings(pick_settings());
            if ($urandom_range(0, 1) == 0)
                send_item(ACT_SAMPLE, $urandom());
            repeat ($urandom_range(1, 4))
            begin
                if ($urandom_range(0, 9) == 0)
                    repeat ($urandom_range(1, 6))
                        send_item(1'($urandom_range(0, 1)), $urandom());
                else
                    run_sweep();
            end
        end

        wait_idle();
        repeat (20) @(negedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[filelist.f]
src/caf_pkg.sv
src/caf_cfg_regs.sv
src/caf_front.sv
src/caf_back.sv
src/contrast_autofocus_sweep.sv
tb/caf_sweep_checker.sv
tb/tb_top.sv
